@@ design/kti_pkg.sv @@
// ----------------------------------------------------------------------------
// kti_pkg
// Shared types and constants of the keyframe timeline interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package kti_pkg;

  // number of timeline entries, 2 to 64
  localparam int unsigned TABLE_SIZE = 64;

  localparam int unsigned IDX_W     = 6;
  localparam int unsigned CNT_W     = IDX_W + 1;
  localparam int unsigned VAL_W     = 16;
  localparam int unsigned NUM_LANES = 4;
  // a load step, then one cycle per quotient bit
  localparam int unsigned DIV_STEPS = VAL_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

  typedef logic signed [VAL_W-1:0] lane_val_t;
  typedef lane_val_t [NUM_LANES-1:0] lane_vec_t;

  typedef struct packed {
    logic [IDX_W-1:0] key_time;
    lane_val_t        value_a;
    lane_val_t        value_b;
    lane_val_t        value_c;
    lane_val_t        value_d;
    logic             last_key;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] sample_index;
    lane_val_t        out_a;
    lane_val_t        out_b;
    lane_val_t        out_c;
    lane_val_t        out_d;
    logic             end_of_table;
    logic             order_error;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_FILL,
    ST_DIV,
    ST_RAMP,
    ST_TAIL
  } state_e;

  typedef enum logic [1:0] {
    SEL_CUR,
    SEL_INTERP,
    SEL_ERR
  } sel_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic step;
  } lane_ctl_t;

endpackage

`default_nettype wire

@@ design/kti_lane.sv @@
// ----------------------------------------------------------------------------
// kti_lane
// One interpolation lane: divides |cur - prev| by the key distance once, then
// walks quotient and remainder forward one sample at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module kti_lane (
  input  logic                        clk_i,
  input  kti_pkg::lane_ctl_t          ctl_i,
  input  kti_pkg::lane_val_t          prev_i,
  input  kti_pkg::lane_val_t          cur_i,
  input  logic [kti_pkg::IDX_W-1:0]   dt_i,
  output kti_pkg::lane_val_t          interp_o
);
  import kti_pkg::*;

  logic signed [VAL_W:0] diff;
  logic        [VAL_W:0] mag;

  logic              neg_q, neg_d;
  logic [VAL_W-1:0]  num_q, num_d;    // dividend, becomes quotient
  logic [IDX_W-1:0]  rem_q, rem_d;
  logic [VAL_W-1:0]  acc_q, acc_d;    // running quotient of |diff|*off/dt
  logic [IDX_W-1:0]  accr_q, accr_d;  // running remainder

  logic [IDX_W:0]    rem_sh;
  logic              ge;
  logic [IDX_W:0]    sum_r;
  logic              wrap;
  logic signed [VAL_W+1:0] res;

  assign diff = {prev_i[VAL_W-1], prev_i} - {cur_i[VAL_W-1], cur_i};

  always_comb begin
    // diff here is prev - cur, so cur - prev is negative when this is positive
    mag    = diff[VAL_W] ? (~diff + 1'b1) : diff;
    rem_sh = {rem_q, num_q[VAL_W-1]};
    ge     = rem_sh >= {1'b0, dt_i};
    sum_r  = {1'b0, accr_q} + {1'b0, rem_q};
    wrap   = sum_r >= {1'b0, dt_i};

    neg_d  = neg_q;
    num_d  = num_q;
    rem_d  = rem_q;
    acc_d  = acc_q;
    accr_d = accr_q;
    if (ctl_i.load) begin
      neg_d  = ~diff[VAL_W] && (diff != '0);
      num_d  = mag[VAL_W-1:0];
      rem_d  = '0;
      acc_d  = '0;
      accr_d = '0;
    end else if (ctl_i.div_step) begin
      rem_d = ge ? IDX_W'(rem_sh - {1'b0, dt_i}) : rem_sh[IDX_W-1:0];
      num_d = {num_q[VAL_W-2:0], ge};
    end else if (ctl_i.step) begin
      accr_d = wrap ? IDX_W'(sum_r - {1'b0, dt_i}) : sum_r[IDX_W-1:0];
      acc_d  = acc_q + num_q + VAL_W'(wrap);
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    num_q  <= num_d;
    rem_q  <= rem_d;
    acc_q  <= acc_d;
    accr_q <= accr_d;
  end

  always_comb begin
    if (neg_q) begin
      res = {{2{prev_i[VAL_W-1]}}, prev_i} - {2'b00, acc_q};
    end else begin
      res = {{2{prev_i[VAL_W-1]}}, prev_i} + {2'b00, acc_q};
    end
  end

  assign interp_o = res[VAL_W-1:0];

endmodule

`default_nettype wire

@@ design/kti_merge.sv @@
// ----------------------------------------------------------------------------
// kti_merge
// Combines the lane results, index and flags into one result word and holds
// it in the output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module kti_merge (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       emit_i,
  input  kti_pkg::sel_e              sel_i,
  input  logic [kti_pkg::IDX_W-1:0]  index_i,
  input  kti_pkg::lane_vec_t         cur_i,
  input  kti_pkg::lane_vec_t         interp_i,
  input  logic                       out_stall_i,
  output logic                       free_o,
  output logic                       out_valid_o,
  output kti_pkg::out_word_t         out_word_o
);
  import kti_pkg::*;

  logic      valid_q, valid_d;
  out_word_t word_q, word_d;
  lane_vec_t vals;

  always_comb begin
    case (sel_i)
      SEL_CUR:    vals = cur_i;
      SEL_INTERP: vals = interp_i;
      default:    vals = '0;
    endcase
    word_d.out_a        = vals[0];
    word_d.out_b        = vals[1];
    word_d.out_c        = vals[2];
    word_d.out_d        = vals[3];
    word_d.order_error  = (sel_i == SEL_ERR);
    word_d.sample_index = (sel_i == SEL_ERR) ? '0 : index_i;
    word_d.end_of_table = (sel_i != SEL_ERR) && (index_i == IDX_W'(TABLE_SIZE - 1));
  end

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (emit_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i) begin
      word_q <= word_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

`default_nettype wire

@@ design/keyframe_timeline_interpolator_unit.sv @@
// ----------------------------------------------------------------------------
// keyframe_timeline_interpolator_unit
// Piecewise linear keyframe interpolation into a sampled timeline.
// ----------------------------------------------------------------------------
// Keyframes are taken one at a time; the input stalls until every sample that
// a keyframe causes has entered the output register. Samples leave at one per
// cycle while the output is not stalled. A first keyframe emits its samples
// directly. A later keyframe first runs the four lane dividers (a load step,
// then one quotient bit a cycle), then emits its samples. A keyframe marked
// last then emits its tail samples. A keyframe whose time does not rise gives
// one error word.
`default_nettype none

module keyframe_timeline_interpolator_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  kti_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output kti_pkg::out_word_t out_word_o
);
  import kti_pkg::*;

  state_e state_q, state_d;

  in_word_t              item_q;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DIV_CNT_W-1:0]  div_cnt_q, div_cnt_d;
  logic [IDX_W-1:0]      prev_time_q;
  lane_vec_t             prev_vals_q;
  logic                  have_q;

  logic       accept;
  logic       emit;
  sel_e       sel;
  lane_ctl_t  ctl;
  logic       finish;
  logic       free;

  lane_vec_t        cur_vals;
  lane_vec_t        interp_vals;
  logic [IDX_W-1:0] dt;
  logic [CNT_W-1:0] t_cur;
  logic [CNT_W-1:0] run_end;

  assign cur_vals[0] = item_q.value_a;
  assign cur_vals[1] = item_q.value_b;
  assign cur_vals[2] = item_q.value_c;
  assign cur_vals[3] = item_q.value_d;

  assign dt      = item_q.key_time - prev_time_q;
  assign t_cur   = {1'b0, item_q.key_time};
  // runs are clipped at the table end
  assign run_end = (t_cur < CNT_W'(TABLE_SIZE)) ? t_cur : CNT_W'(TABLE_SIZE);

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (have_q && (in_word_i.key_time <= prev_time_q)) begin
            state_d = ST_ERR;
          end else if (!have_q) begin
            state_d = ST_FILL;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_ERR: begin
        if (free) begin
          state_d = ST_IDLE;
        end
      end
      ST_FILL, ST_RAMP: begin
        if (cnt_q >= run_end) begin
          state_d = item_q.last_key ? ST_TAIL : ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_cnt_q == DIV_CNT_W'(DIV_STEPS)) begin
          state_d = ST_RAMP;
        end
      end
      ST_TAIL: begin
        if (cnt_q >= CNT_W'(TABLE_SIZE)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    emit      = 1'b0;
    sel       = SEL_CUR;
    ctl       = '0;
    finish    = 1'b0;
    cnt_d     = cnt_q;
    div_cnt_d = div_cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cnt_d     = have_q ? {1'b0, prev_time_q} : '0;
          div_cnt_d = '0;
        end
      end
      ST_ERR: begin
        if (free) begin
          emit = 1'b1;
          sel  = SEL_ERR;
        end
      end
      ST_FILL, ST_RAMP: begin
        if (cnt_q >= run_end) begin
          if (item_q.last_key) begin
            cnt_d = t_cur;
          end else begin
            finish = 1'b1;
          end
        end else if (free) begin
          emit     = 1'b1;
          sel      = (state_q == ST_RAMP) ? SEL_INTERP : SEL_CUR;
          ctl.step = (state_q == ST_RAMP);
          cnt_d    = cnt_q + 1'b1;
        end
      end
      ST_DIV: begin
        ctl.load     = (div_cnt_q == '0);
        ctl.div_step = (div_cnt_q != '0);
        div_cnt_d    = div_cnt_q + 1'b1;
      end
      ST_TAIL: begin
        if (cnt_q >= CNT_W'(TABLE_SIZE)) begin
          finish = 1'b1;
        end else if (free) begin
          emit  = 1'b1;
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      div_cnt_q   <= '0;
      prev_time_q <= '0;
      prev_vals_q <= '0;
      have_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      div_cnt_q <= div_cnt_d;
      if (finish) begin
        prev_time_q <= item_q.key_time;
        prev_vals_q <= cur_vals;
        have_q      <= !item_q.last_key;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_word_i;
    end
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    kti_lane u_lane (
      .clk_i    (clk_i),
      .ctl_i    (ctl),
      .prev_i   (prev_vals_q[g]),
      .cur_i    (cur_vals[g]),
      .dt_i     (dt),
      .interp_o (interp_vals[g])
    );
  end

  kti_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .sel_i       (sel),
    .index_i     (cnt_q[IDX_W-1:0]),
    .cur_i       (cur_vals),
    .interp_i    (interp_vals),
    .out_stall_i (out_stall_i),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

@@ design/kti_checker.sv @@
// ----------------------------------------------------------------------------
// kti_checker
// Port-level checks on the keyframe timeline interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

module kti_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_o,
  input  logic               out_valid_o,
  input  logic               out_stall_i,
  input  kti_pkg::out_word_t out_word_o
);
  import kti_pkg::*;

  // an error word carries nothing but its flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.order_error) |->
      (out_word_o.sample_index == '0) && !out_word_o.end_of_table &&
      (out_word_o.out_a == '0) && (out_word_o.out_b == '0) &&
      (out_word_o.out_c == '0) && (out_word_o.out_d == '0))
    else $error("error word with nonzero payload");

  // end of table flag marks exactly the last index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.order_error) |->
      (out_word_o.end_of_table == (out_word_o.sample_index == IDX_W'(TABLE_SIZE - 1))))
    else $error("end_of_table does not match sample_index");

  // a taken keyframe raises the input stall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after a word was taken");

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_word_o)))
    else $error("stalled result word changed");

endmodule

bind keyframe_timeline_interpolator_unit kti_checker u_kti_checker (.*);

`default_nettype wire
